@@ design/wtv_pkg.sv @@
`default_nettype none

package wtv_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS     = 16;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int CMD_W           = 2;
  localparam int IDX_W           = 12;
  localparam int STEP_W          = 28;
  localparam int ALEN_W          = 12;
  localparam int COEF_W          = 24;
  localparam int REL_W           = 24;
  localparam int TAIL_W          = 16;
  localparam int AMP_W           = 16;
  localparam int CNT_W           = 25;
  localparam int ENV_W           = 25;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 28;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 24;

  // Shared multiplier: signed operands, full-width product
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;

  // Unity gain in Q1.24
  localparam logic [ENV_W-1:0] ONE_Q24 = 25'h100_0000;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MIX   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RECIP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_AT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd7;

  // Register reset values
  localparam logic [STEP_W-1:0] RST_PHASE_STEP   = 28'd0;
  localparam logic [ALEN_W-1:0] RST_ATTACK_LEN   = 12'd240;
  localparam logic [COEF_W-1:0] RST_ATTACK_RECIP = 24'd69905;
  localparam logic [REL_W-1:0]  RST_RELEASE_AT   = 24'd0;
  localparam logic [TAIL_W-1:0] RST_TAIL_LEN     = 16'd9600;
  localparam logic [COEF_W-1:0] RST_DECAY_COEF   = 24'd16775952;
  localparam logic [COEF_W-1:0] RST_RELEASE_COEF = 24'd16765567;
  localparam logic [AMP_W-1:0]  RST_AMPLITUDE    = 16'd9830;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RDA,
    S_RDB,
    S_INTERP,
    S_GAIN,
    S_ENV,
    S_AMP,
    S_VOICE,
    S_DONE
  } state_t;

  // Operand pair handed to the shared multiplier
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

endpackage

`default_nettype wire

@@ design/wtv_ram.sv @@
`default_nettype none

module wtv_ram #(
  parameter int WIDTH = wtv_pkg::SAMPLE_BITS,
  parameter int DEPTH = wtv_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/wtv_mul.sv @@
`default_nettype none

module wtv_mul (
  input  wire logic                              clk,
  input  wire wtv_pkg::mul_op_t                  op,
  output logic signed [wtv_pkg::PROD_W-1:0]      prod
);

  // Multiply signed operands, register the full product
  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

`default_nettype wire

@@ design/wavetable_voice_with_envelope_unit.sv @@
`default_nettype none
// Sequence: load, start-note and unused requests go from accept straight to the result
// state; a mix request passes check, two table reads, interpolation, a gain step (only in
// the attack ramp), envelope, amplitude and voice sum, or only check once the note has ended.
// A new request is taken only in idle, not before the last result is placed on the output,
// which waits while the output is held; the single shared multiplier is visited four or five times per mix.
// Reset (rst, synchronous): registers to defaults, voice silent; table contents undefined.

module wavetable_voice_with_envelope_unit #(
  parameter int TABLE_DEPTH = wtv_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [wtv_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // table_index, table_value, mix_in
  input  wire logic [wtv_pkg::CMD_W-1:0]         s_axis_tuser,  // cmd
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [wtv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // mix_out, note_active
  // register writes
  input  wire logic                              cfg_we,
  input  wire logic [wtv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wtv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int PW    = AW + 16;
  localparam int SB    = wtv_pkg::SAMPLE_BITS;
  localparam int IDX_W = wtv_pkg::IDX_W;
  localparam int MUL_W = wtv_pkg::MUL_W;
  localparam int PROD_W = wtv_pkg::PROD_W;
  localparam int ENV_W = wtv_pkg::ENV_W;
  localparam int CNT_W = wtv_pkg::CNT_W;

  // Configuration registers
  logic [wtv_pkg::STEP_W-1:0] phase_step;
  logic [wtv_pkg::ALEN_W-1:0] attack_len;
  logic [wtv_pkg::COEF_W-1:0] attack_recip;
  logic [wtv_pkg::REL_W-1:0]  release_at;
  logic [wtv_pkg::TAIL_W-1:0] tail_len;
  logic [wtv_pkg::COEF_W-1:0] decay_coef;
  logic [wtv_pkg::COEF_W-1:0] release_coef;
  logic [wtv_pkg::AMP_W-1:0]  amplitude;

  // Voice state
  wtv_pkg::state_t   state;
  wtv_pkg::state_t   state_next;
  logic [PW-1:0]     phase_acc;
  logic [ENV_W-1:0]  envelope;
  logic [CNT_W-1:0]  sample_count;
  logic              sounding;

  // Per-request working registers
  logic signed [SB-1:0] mix_q;
  logic signed [SB-1:0] a_q;
  logic signed [SB-1:0] s_q;
  logic                 attack_q;
  logic                 decay_q;
  logic [SB-1:0]        res_mix;
  logic                 res_active;

  // Input fields
  logic [wtv_pkg::CMD_W-1:0] in_cmd;
  logic [IDX_W-1:0]          in_index;
  logic [SB-1:0]             in_value;
  logic [SB-1:0]             in_mix;
  logic                      accept;

  assign in_cmd   = s_axis_tuser;
  assign in_index = s_axis_tdata[IDX_W-1:0];
  assign in_value = s_axis_tdata[IDX_W +: SB];
  assign in_mix   = s_axis_tdata[IDX_W+SB +: SB];

  assign s_axis_tready = (state == wtv_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Table addressing
  logic [AW+IDX_W-1:0] load_ext;
  logic [AW-1:0]       load_addr;
  logic [AW-1:0]       idx_cur;
  logic [AW-1:0]       idx_nxt;
  logic [15:0]         frac;

  assign load_ext  = {{AW{1'b0}}, in_index};
  assign load_addr = load_ext[AW-1:0];
  assign idx_cur   = phase_acc[PW-1:16];
  assign idx_nxt   = idx_cur + 1'b1;
  assign frac      = phase_acc[15:0];

  // Wavetable memory
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SB-1:0] ram_rdata;

  wtv_ram #(
    .WIDTH (SB),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_addr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier
  wtv_pkg::mul_op_t         mul_op;
  logic signed [PROD_W-1:0] prod;

  wtv_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // Note-length check
  logic [CNT_W:0] note_len;
  logic           note_on;

  assign note_len = (CNT_W + 1)'(release_at) + (CNT_W + 1)'(tail_len);
  assign note_on  = sounding && ({1'b0, sample_count} < note_len);

  // Interpolation, gain clamp, envelope pick and voice sum
  logic [SB:0]          interp_sum;
  logic                 gain_over;
  logic [ENV_W-1:0]     gain;
  logic [ENV_W-1:0]     e_now;
  logic [ENV_W-1:0]     ae;
  logic [SB:0]          diff;
  logic [SB:0]          voice;
  logic [SB+1:0]        mix_sum;
  logic [SB-1:0]        mix_sat;
  logic [wtv_pkg::COEF_W-1:0] env_coef;

  assign diff       = {ram_rdata[SB-1], ram_rdata} - {a_q[SB-1], a_q};
  assign interp_sum = {a_q[SB-1], a_q} + prod[16+SB:16];
  assign gain_over  = (|prod[PROD_W-1:ENV_W]) || (prod[ENV_W-1] && (|prod[ENV_W-2:0]));
  assign gain       = gain_over ? wtv_pkg::ONE_Q24 : prod[ENV_W-1:0];
  assign e_now      = attack_q ? prod[24+ENV_W-1:24] : envelope;
  assign ae         = prod[16+ENV_W-1:16];
  assign env_coef   = decay_q ? decay_coef : release_coef;
  assign voice      = prod[24+SB:24];
  assign mix_sum    = {{2{mix_q[SB-1]}}, mix_q} + {voice[SB], voice};

  // Saturate the sum to the sample width
  always_comb begin
    if (mix_sum[SB+1:SB-1] == 3'b000 || mix_sum[SB+1:SB-1] == 3'b111) begin
      mix_sat = mix_sum[SB-1:0];
    end else if (mix_sum[SB+1]) begin
      mix_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      mix_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wtv_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (in_cmd == wtv_pkg::CMD_MIX) ? wtv_pkg::S_CHECK : wtv_pkg::S_DONE;
        end
      end
      wtv_pkg::S_CHECK:  state_next = note_on ? wtv_pkg::S_RDA : wtv_pkg::S_DONE;
      wtv_pkg::S_RDA:    state_next = wtv_pkg::S_RDB;
      wtv_pkg::S_RDB:    state_next = wtv_pkg::S_INTERP;
      wtv_pkg::S_INTERP: state_next = attack_q ? wtv_pkg::S_GAIN : wtv_pkg::S_ENV;
      wtv_pkg::S_GAIN:   state_next = wtv_pkg::S_ENV;
      wtv_pkg::S_ENV:    state_next = wtv_pkg::S_AMP;
      wtv_pkg::S_AMP:    state_next = wtv_pkg::S_VOICE;
      wtv_pkg::S_VOICE:  state_next = wtv_pkg::S_DONE;
      wtv_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = wtv_pkg::S_IDLE;
        end
      end
      default:           state_next = wtv_pkg::S_IDLE;
    endcase
  end

  // Memory controls and multiplier operands per step
  always_comb begin
    ram_we    = accept && (in_cmd == wtv_pkg::CMD_LOAD);
    ram_raddr = idx_cur;
    mul_op.a  = '0;
    mul_op.b  = '0;
    case (state)
      wtv_pkg::S_RDA: begin
        ram_raddr = idx_nxt;
      end
      wtv_pkg::S_RDB: begin
        mul_op.a = {{(MUL_W-SB-1){diff[SB]}}, diff};
        mul_op.b = {{(MUL_W-16){1'b0}}, frac};
      end
      wtv_pkg::S_INTERP: begin
        if (attack_q) begin
          mul_op.a = {{(MUL_W-CNT_W){1'b0}}, sample_count};
          mul_op.b = {{(MUL_W-wtv_pkg::COEF_W){1'b0}}, attack_recip};
        end else begin
          mul_op.a = {{(MUL_W-ENV_W){1'b0}}, envelope};
          mul_op.b = {{(MUL_W-wtv_pkg::COEF_W){1'b0}}, env_coef};
        end
      end
      wtv_pkg::S_GAIN: begin
        mul_op.a = {{(MUL_W-ENV_W){1'b0}}, envelope};
        mul_op.b = {{(MUL_W-ENV_W){1'b0}}, gain};
      end
      wtv_pkg::S_ENV: begin
        mul_op.a = {{(MUL_W-wtv_pkg::AMP_W){1'b0}}, amplitude};
        mul_op.b = {{(MUL_W-ENV_W){1'b0}}, e_now};
      end
      wtv_pkg::S_AMP: begin
        mul_op.a = {{(MUL_W-ENV_W){1'b0}}, ae};
        mul_op.b = {{(MUL_W-SB){s_q[SB-1]}}, s_q};
      end
      default: begin
        mul_op.a = '0;
        mul_op.b = '0;
      end
    endcase
  end

  // Control state, registers and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wtv_pkg::S_IDLE;
      phase_step    <= wtv_pkg::RST_PHASE_STEP;
      attack_len    <= wtv_pkg::RST_ATTACK_LEN;
      attack_recip  <= wtv_pkg::RST_ATTACK_RECIP;
      release_at    <= wtv_pkg::RST_RELEASE_AT;
      tail_len      <= wtv_pkg::RST_TAIL_LEN;
      decay_coef    <= wtv_pkg::RST_DECAY_COEF;
      release_coef  <= wtv_pkg::RST_RELEASE_COEF;
      amplitude     <= wtv_pkg::RST_AMPLITUDE;
      phase_acc     <= '0;
      envelope      <= '0;
      sample_count  <= '0;
      sounding      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          wtv_pkg::REG_PHASE_STEP:   phase_step   <= cfg_data[wtv_pkg::STEP_W-1:0];
          wtv_pkg::REG_ATTACK_LEN:   attack_len   <= cfg_data[wtv_pkg::ALEN_W-1:0];
          wtv_pkg::REG_ATTACK_RECIP: attack_recip <= cfg_data[wtv_pkg::COEF_W-1:0];
          wtv_pkg::REG_RELEASE_AT:   release_at   <= cfg_data[wtv_pkg::REL_W-1:0];
          wtv_pkg::REG_TAIL_LEN:     tail_len     <= cfg_data[wtv_pkg::TAIL_W-1:0];
          wtv_pkg::REG_DECAY_COEF:   decay_coef   <= cfg_data[wtv_pkg::COEF_W-1:0];
          wtv_pkg::REG_RELEASE_COEF: release_coef <= cfg_data[wtv_pkg::COEF_W-1:0];
          wtv_pkg::REG_AMPLITUDE:    amplitude    <= cfg_data[wtv_pkg::AMP_W-1:0];
          default: begin
          end
        endcase
      end

      // Start a note, end it, advance phase, envelope and count
      case (state)
        wtv_pkg::S_IDLE: begin
          if (accept && in_cmd == wtv_pkg::CMD_START) begin
            phase_acc    <= '0;
            sample_count <= '0;
            envelope     <= wtv_pkg::ONE_Q24;
            sounding     <= 1'b1;
          end
        end
        wtv_pkg::S_CHECK: begin
          if (!note_on) begin
            sounding <= 1'b0;
          end
        end
        wtv_pkg::S_RDB: begin
          phase_acc <= phase_acc + PW'(phase_step);
        end
        wtv_pkg::S_ENV: begin
          if (!attack_q) begin
            envelope <= prod[24+ENV_W-1:24];
          end
        end
        wtv_pkg::S_VOICE: begin
          sample_count <= sample_count + 1'b1;
        end
        default: begin
        end
      endcase

      // Hold the output until taken
      if (state == wtv_pkg::S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Per-request payload
  always_ff @(posedge clk) begin
    case (state)
      wtv_pkg::S_IDLE: begin
        if (accept) begin
          mix_q   <= in_mix;
          res_mix <= in_mix;
          case (in_cmd)
            wtv_pkg::CMD_START: res_active <= 1'b1;
            default:            res_active <= sounding;
          endcase
        end
      end
      wtv_pkg::S_CHECK: begin
        attack_q <= sample_count < CNT_W'(attack_len);
        decay_q  <= sample_count < CNT_W'(release_at);
        if (!note_on) begin
          res_active <= 1'b0;
        end
      end
      wtv_pkg::S_RDA: begin
        a_q <= ram_rdata;
      end
      wtv_pkg::S_INTERP: begin
        s_q <= interp_sum[SB-1:0];
      end
      wtv_pkg::S_VOICE: begin
        res_mix    <= mix_sat;
        res_active <= 1'b1;
      end
      default: begin
      end
    endcase

    if (state == wtv_pkg::S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {{(wtv_pkg::OUT_DATA_W-SB-1){1'b0}}, res_active, res_mix};
    end
  end

  // Envelope never exceeds unity
  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    envelope <= wtv_pkg::ONE_Q24)
    else $error("envelope above unity");

  // Starting a note restarts count and envelope
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == wtv_pkg::CMD_START) |=>
      (sounding && sample_count == '0 && phase_acc == '0 && envelope == wtv_pkg::ONE_Q24))
    else $error("start request did not restart the voice");

  // A finished mix step reports a sounding voice
  a_voice_done: assert property (@(posedge clk) disable iff (rst)
    (state == wtv_pkg::S_VOICE) |=> (state == wtv_pkg::S_DONE && res_active))
    else $error("mix step finished without active flag");

  // Count only advances in the final mix step
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state != wtv_pkg::S_VOICE && !accept) |=> $stable(sample_count))
    else $error("sample count moved outside a mix step");

endmodule

`default_nettype wire
